### rtl/core/bfc_pkg.sv
// Package for the packed-BCD coprocessor: beat structs, command and opcode codes,
// sequencer state and pass kinds, and the decimal byte add and subtract.
// No dependencies.
package bfc_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] opcode;
        logic [4:0] byte_address;
        logic [7:0] write_data;
    } bfc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] status;
    } bfc_out_t;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PORT1 = 2'd2;
    localparam logic [1:0] CMD_PORT2 = 2'd3;

    // Port-1 opcodes.
    localparam logic [7:0] OP1_X_FROM_T = 8'h04;
    localparam logic [7:0] OP1_Y_FROM_T = 8'h05;
    localparam logic [7:0] OP1_XCHG_TX  = 8'h08;
    localparam logic [7:0] OP1_CLR_X    = 8'h10;
    localparam logic [7:0] OP1_CLR_Y    = 8'h11;
    localparam logic [7:0] OP1_SWAP_XY  = 8'h80;

    // Port-2 opcodes with an arithmetic or copy action.
    localparam logic [7:0] OP2_EXP_ADD   = 8'h00;
    localparam logic [7:0] OP2_EXP_SUB   = 8'h01;
    localparam logic [7:0] OP2_XSUBY_A   = 8'h41;
    localparam logic [7:0] OP2_XSUBY_B   = 8'hC1;
    localparam logic [7:0] OP2_YSUBX_A   = 8'h43;
    localparam logic [7:0] OP2_YSUBX_B   = 8'hC3;
    localparam logic [7:0] OP2_XADDY_A   = 8'hC0;
    localparam logic [7:0] OP2_XADDY_B   = 8'hC2;
    localparam logic [7:0] OP2_COPY_X    = 8'hD0;

    localparam logic [1:0] SHIFT_RIGHT = 2'b10;
    localparam logic [1:0] SHIFT_LEFT  = 2'b11;

    // Register regions inside the shared byte memory.
    localparam logic [1:0] RG_X = 2'd0;
    localparam logic [1:0] RG_Y = 2'd1;
    localparam logic [1:0] RG_T = 2'd2;

    // Fixed layout: mantissa bytes 0..6, exponent bytes 7..8.
    localparam int MANT_LAST = 6;
    localparam int EXP_LO    = 7;
    localparam int EXP_HI    = 8;

    localparam int ST_ZERO_BIT  = 6;
    localparam int ST_HALF_BIT  = 4;
    localparam int ST_CARRY_BIT = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_RDA,
        ST_RDB,
        ST_WR,
        ST_WR2,
        ST_HOSTRD,
        ST_DONE
    } bfc_state_t;

    typedef enum logic [2:0] {
        K_COPY,
        K_XCHG,
        K_CLEAR,
        K_ARITH,
        K_INC
    } bfc_kind_t;

    typedef struct packed {
        logic [7:0] value;
        logic       cout;
        logic       half;
    } bcd_res_t;

    function automatic bcd_res_t bcd_add(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] s_lo;
        logic [3:0] lo;
        logic       c;
        logic [9:0] s;
        logic [9:0] s_adj;
        bcd_res_t   r;
        s_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        if (s_lo > 5'd9)
        begin
            lo = s_lo[3:0] + 4'd6;
            c  = 1'b1;
        end
        else
        begin
            lo = s_lo[3:0];
            c  = 1'b0;
        end
        s = {6'd0, lo} + {2'd0, a[7:4], 4'd0} + {2'd0, b[7:4], 4'd0} + {5'd0, c, 4'd0};
        s_adj = s + 10'h060;
        r.half = c;
        if (s > 10'h09F)
        begin
            r.value = s_adj[7:0];
            r.cout  = 1'b1;
        end
        else
        begin
            r.value = s[7:0];
            r.cout  = 1'b0;
        end
        return r;
    endfunction

    function automatic bcd_res_t bcd_sub(input logic [7:0] a, input logic [7:0] b);
        logic signed [5:0]  dl;
        logic [5:0]         dl_adj;
        logic [3:0]         lo;
        logic               c;
        logic signed [10:0] d;
        logic [10:0]        d_adj;
        bcd_res_t           r;
        dl = $signed({2'd0, a[3:0]}) - $signed({2'd0, b[3:0]});
        dl_adj = dl - 6'sd6;
        if ((dl < 6'sd0) || (dl > 6'sd9))
        begin
            lo = dl_adj[3:0];
            c  = 1'b1;
        end
        else
        begin
            lo = dl[3:0];
            c  = 1'b0;
        end
        d = $signed({7'd0, lo}) + $signed({3'd0, a[7:4], 4'd0})
            - $signed({3'd0, b[7:4], 4'd0}) - $signed({6'd0, c, 4'd0});
        d_adj = d - 11'sd96;
        r.half = c;
        if ((d < 11'sd0) || (d > 11'sd159))
        begin
            r.value = d_adj[7:0];
            r.cout  = 1'b1;
        end
        else
        begin
            r.value = d[7:0];
            r.cout  = 1'b0;
        end
        return r;
    endfunction

endpackage

### rtl/core/bcd_float_coprocessor.sv
// Top level of the packed-BCD coprocessor: X, Y and T live in one byte-wide
// synchronous memory that a byte-serial sequencer reads, modifies and writes back.
// Depends on bfc_pkg.
//
//  channel   ports                     handshake
//  --------  ------------------------  ----------------------------------------
//  command   start, request            beat taken when start is high, busy low
//  result    done, response            one beat per command, valid one cycle
//
// A host read or write touches one byte. Other commands run byte passes: a copy,
// clear or exponent step reads and writes each byte, an add or subtract reads
// both operands before its write, and an exchange reads two bytes and writes
// two. The longest item is the 16-byte exchange of T and X. Reset clears control
// state and the per-entry valid bits, so every byte reads zero until written.
// The result cannot be stalled.
module bcd_float_coprocessor #(
    parameter int REG_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bfc_pkg::bfc_in_t  request,
    output logic              busy,
    output logic              done,
    output bfc_pkg::bfc_out_t response
);
    import bfc_pkg::*;

    localparam int IW    = $clog2(REG_BYTES);
    localparam int AW    = IW + 2;
    localparam int DEPTH = 3 * (2 ** IW);
    localparam logic [IW-1:0] LAST_IDX  = IW'(REG_BYTES - 1);
    localparam logic [IW-1:0] MANT_IDX  = IW'(MANT_LAST);
    localparam logic [IW-1:0] EXPLO_IDX = IW'(EXP_LO);
    localparam logic [IW-1:0] EXPHI_IDX = IW'(EXP_HI);

    typedef struct packed {
        logic          active;
        bfc_kind_t     kind;
        logic [1:0]    ra;
        logic [1:0]    rb;
        logic [1:0]    rw;
        logic [IW-1:0] first;
        logic [IW-1:0] last;
        logic          down;
        logic          shr;
        logic          shl;
        logic          sub;
        logic          expz;
    } pass_t;

    function automatic pass_t pass_for(input logic [1:0] cmd, input logic [7:0] op,
                                       input logic [1:0] stage);
        pass_t p;
        p = '0;
        p.kind = K_COPY;
        p.last = LAST_IDX;
        if (cmd == CMD_PORT1 && stage == 2'd0)
        begin
            case (op)
                OP1_X_FROM_T:
                begin
                    p.active = 1'b1; p.ra = RG_T; p.rw = RG_X;
                end
                OP1_Y_FROM_T:
                begin
                    p.active = 1'b1; p.ra = RG_T; p.rw = RG_Y;
                end
                OP1_XCHG_TX:
                begin
                    p.active = 1'b1; p.kind = K_XCHG; p.ra = RG_X; p.rb = RG_T;
                end
                OP1_CLR_X:
                begin
                    p.active = 1'b1; p.kind = K_CLEAR; p.rw = RG_X; p.last = EXPHI_IDX;
                end
                OP1_CLR_Y:
                begin
                    p.active = 1'b1; p.kind = K_CLEAR; p.rw = RG_Y; p.last = EXPHI_IDX;
                end
                OP1_SWAP_XY:
                begin
                    p.active = 1'b1; p.kind = K_XCHG; p.ra = RG_X; p.rb = RG_Y;
                    p.last = EXPHI_IDX;
                end
                default: p.active = 1'b0;
            endcase
        end
        else if (cmd == CMD_PORT2)
        begin
            case (stage)
                2'd0:
                begin
                    // Load T, folding the digit shift into the same pass.
                    p.active = 1'b1;
                    p.ra = op[1] ? RG_Y : RG_X;
                    p.rw = RG_T;
                    p.shr = (op[3:2] == SHIFT_RIGHT);
                    p.shl = (op[3:2] == SHIFT_LEFT);
                    if (p.shl)
                    begin
                        p.down  = 1'b1;
                        p.first = LAST_IDX;
                        p.last  = '0;
                    end
                end
                2'd1:
                begin
                    p.active = op[4];
                    p.kind = K_INC; p.ra = RG_T; p.rw = RG_T;
                    p.first = EXPLO_IDX; p.last = EXPHI_IDX;
                    p.sub = op[0]; p.expz = 1'b1;
                end
                2'd2:
                begin
                    p.kind = K_ARITH; p.rw = RG_T;
                    case (op)
                        OP2_EXP_ADD, OP2_EXP_SUB:
                        begin
                            p.active = 1'b1; p.ra = RG_X; p.rb = RG_Y;
                            p.first = EXPLO_IDX; p.last = EXPHI_IDX;
                            p.sub = op[0]; p.expz = 1'b1;
                        end
                        OP2_XSUBY_A, OP2_XSUBY_B:
                        begin
                            p.active = 1'b1; p.ra = RG_X; p.rb = RG_Y;
                            p.last = MANT_IDX; p.sub = 1'b1;
                        end
                        OP2_YSUBX_A, OP2_YSUBX_B:
                        begin
                            p.active = 1'b1; p.ra = RG_Y; p.rb = RG_X;
                            p.last = MANT_IDX; p.sub = 1'b1;
                        end
                        OP2_XADDY_A, OP2_XADDY_B:
                        begin
                            p.active = 1'b1; p.ra = RG_X; p.rb = RG_Y;
                            p.last = MANT_IDX;
                        end
                        OP2_COPY_X:
                        begin
                            p.active = 1'b1; p.kind = K_COPY; p.ra = RG_X;
                            p.last = EXPHI_IDX;
                        end
                        default: p.active = 1'b0;
                    endcase
                end
                default: p.active = 1'b0;
            endcase
        end
        return p;
    endfunction

    bfc_state_t    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [7:0]    op_reg, op_next;
    logic [1:0]    stage_reg, stage_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]    a_reg, a_next;
    logic [3:0]    nib_reg, nib_next;
    logic          c_reg, c_next;
    logic          zacc_reg, zacc_next;
    logic          rdok_reg, rdok_next;
    logic          zero_reg, zero_next;
    logic          carry_reg, carry_next;
    logic          half_reg, half_next;

    logic [7:0]    mem [DEPTH];
    logic          valid_reg [DEPTH];
    logic [7:0]    mem_q_reg;
    logic          vld_q_reg;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    wdata;
    logic          we;
    logic [7:0]    rdata;

    pass_t         cur;
    bcd_res_t      res;
    logic [7:0]    opa, opb, bb;
    logic          advance;
    logic [1:0]    req_region;

    assign rdata = vld_q_reg ? mem_q_reg : 8'd0;
    assign cur   = pass_for(cmd_reg, op_reg, stage_reg);
    assign req_region = request.byte_address[4] ? RG_Y : RG_X;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            vld_q_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_READ;
            op_reg    <= 8'd0;
            stage_reg <= 2'd0;
            idx_reg   <= '0;
            c_reg     <= 1'b0;
            zacc_reg  <= 1'b0;
            rdok_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            carry_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            op_reg    <= op_next;
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
            c_reg     <= c_next;
            zacc_reg  <= zacc_next;
            rdok_reg  <= rdok_next;
            zero_reg  <= zero_next;
            carry_reg <= carry_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        nib_reg <= nib_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        op_next    = op_reg;
        stage_next = stage_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        nib_next   = nib_reg;
        c_next     = c_reg;
        zacc_next  = zacc_reg;
        rdok_next  = rdok_reg;
        zero_next  = zero_reg;
        carry_next = carry_reg;
        half_next  = half_reg;
        raddr      = {cur.ra, idx_reg};
        waddr      = {cur.rw, idx_reg};
        wdata      = 8'd0;
        we         = 1'b0;
        advance    = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        response.read_data = 8'd0;
        response.status    = 7'd0;
        response.status[ST_ZERO_BIT]  = zero_reg;
        response.status[ST_HALF_BIT]  = half_reg;
        response.status[ST_CARRY_BIT] = carry_reg;
        opa = (cur.kind == K_INC) ? rdata : a_reg;
        opb = (cur.kind == K_INC) ? 8'd0 : rdata;
        bb  = opb + {7'd0, c_reg};
        res = cur.sub ? bcd_sub(opa, bb) : bcd_add(opa, bb);

        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                raddr = {req_region, request.byte_address[IW-1:0]};
                if (start)
                begin
                    cmd_next   = request.command;
                    op_next    = request.opcode;
                    stage_next = 2'd0;
                    rdok_next  = ({1'b0, request.byte_address[3:0]} < 5'(REG_BYTES));
                    case (request.command)
                        CMD_READ: state_next = ST_HOSTRD;
                        CMD_WRITE:
                        begin
                            waddr = {req_region, request.byte_address[IW-1:0]};
                            wdata = request.write_data;
                            we    = rdok_next;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_PASS;
                    endcase
                end
            end
            ST_PASS:
            begin
                if (stage_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
                else if (cur.active)
                begin
                    idx_next  = cur.first;
                    c_next    = (cur.kind == K_INC);
                    zacc_next = 1'b0;
                    nib_next  = 4'd0;
                    state_next = ST_RDA;
                end
                else
                begin
                    stage_next = stage_reg + 2'd1;
                end
            end
            ST_RDA:
            begin
                raddr = {cur.ra, idx_reg};
                if (cur.kind == K_ARITH || cur.kind == K_XCHG)
                begin
                    state_next = ST_RDB;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_RDB:
            begin
                a_next = rdata;
                raddr  = {cur.rb, idx_reg};
                state_next = ST_WR;
            end
            ST_WR:
            begin
                we = 1'b1;
                case (cur.kind)
                    K_COPY:
                    begin
                        wdata   = rdata;
                        advance = 1'b1;
                        // Digits move across bytes only within the mantissa.
                        if (idx_reg <= MANT_IDX)
                        begin
                            if (cur.shr)
                            begin
                                wdata    = {rdata[3:0], nib_reg};
                                nib_next = rdata[7:4];
                            end
                            else if (cur.shl)
                            begin
                                wdata    = {nib_reg, rdata[7:4]};
                                nib_next = rdata[3:0];
                            end
                        end
                    end
                    K_XCHG:
                    begin
                        waddr = {cur.ra, idx_reg};
                        wdata = rdata;
                        state_next = ST_WR2;
                    end
                    K_CLEAR:
                    begin
                        wdata   = 8'd0;
                        advance = 1'b1;
                    end
                    K_ARITH, K_INC:
                    begin
                        wdata      = res.value;
                        c_next     = res.cout;
                        half_next  = res.half;
                        carry_next = res.cout;
                        zacc_next  = zacc_reg | (|res.value) | (cur.expz & res.cout);
                        zero_next  = !zacc_next;
                        advance    = 1'b1;
                    end
                    default: advance = 1'b1;
                endcase
            end
            ST_WR2:
            begin
                we      = 1'b1;
                waddr   = {cur.rb, idx_reg};
                wdata   = a_reg;
                advance = 1'b1;
            end
            ST_HOSTRD:
            begin
                done = 1'b1;
                response.read_data = rdok_reg ? rdata : 8'd0;
                state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // Each byte step finishes its write before the next read is issued,
        // so a read never overlaps a pending write to the same entry.
        if (advance)
        begin
            if (idx_reg == cur.last)
            begin
                stage_next = stage_reg + 2'd1;
                state_next = ST_PASS;
            end
            else
            begin
                idx_next   = cur.down ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                state_next = ST_RDA;
            end
        end
    end

endmodule

### rtl/core/bfc_checker.sv
// Port-level checker for the packed-BCD coprocessor, bound to the top level.
// Depends on bfc_pkg and bcd_float_coprocessor.
module bfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bfc_pkg::bfc_out_t response
);
    import bfc_pkg::*;

    // A result beat only ever closes a command that is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat not followed by idle");

    a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.status[5] == 1'b0 && response.status[3:1] == 3'd0))
        else $error("reserved status bits set");

endmodule

bind bcd_float_coprocessor bfc_checker u_bfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);
